/* hw/rtl/serial_packet_request_deframer_top_assert.svh */
// Assertion macros used by the deframer top level.
`ifndef SERIAL_PACKET_REQUEST_DEFRAMER_TOP_ASSERT_SVH
`define SERIAL_PACKET_REQUEST_DEFRAMER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPDF_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SPDF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/spdf_pkg.sv */
package spdf_pkg;

    localparam logic [7:0] HEADER_BYTE  = 8'd170;
    localparam logic [7:0] REQUEST_BYTE = 8'd85;

    localparam int BUFFER_BYTES_DEF     = 256;
    localparam int STATE_AREA_BYTES_DEF = 6;
    localparam int QUEUE_DEPTH_DEF      = 4;

    typedef enum logic [1:0] {
        ACT_START   = 2'd0,
        ACT_BYTE    = 2'd1,
        ACT_TIMEOUT = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        KIND_TX       = 2'd0,
        KIND_DATA     = 2'd1,
        KIND_FINISHED = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_HEADER  = 3'd1,
        ST_TRUNC   = 3'd2,
        ST_CORRUPT = 3'd3,
        ST_OFFLINE = 3'd4
    } t_status;

    typedef enum logic [5:0] {
        PH_IDLE   = 6'b000001,
        PH_HEADER = 6'b000010,
        PH_ID     = 6'b000100,
        PH_LEN    = 6'b001000,
        PH_DATA   = 6'b010000,
        PH_SUM    = 6'b100000
    } t_phase;

    // One queued unit of work. A request expands to three transmit results:
    // the request byte, byte_value (the command) and req_id (the last id).
    typedef struct packed {
        logic       is_req;
        t_kind      kind;
        logic [7:0] byte_value;
        logic [7:0] data_index;
        logic       to_state_area;
        t_status    status;
        logic       accepted;
        logic [7:0] frame_length;
        logic [7:0] req_id;
    } t_desc;

endpackage

/* hw/rtl/spdf_front.sv */
module spdf_front #(
    parameter int BUFFER_BYTES     = spdf_pkg::BUFFER_BYTES_DEF,
    parameter int STATE_AREA_BYTES = spdf_pkg::STATE_AREA_BYTES_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic [1:0]      i_action,
    input  logic [7:0]      i_command,
    input  logic [7:0]      i_rx_byte,
    input  logic            i_cfg_we,
    input  logic [7:0]      i_cfg_data,
    output logic            o_desc_valid,
    output spdf_pkg::t_desc o_desc
);

    spdf_pkg::t_phase  r_phase, n_phase;
    spdf_pkg::t_status r_link, n_link;
    logic [7:0] r_state_cmd;
    logic [7:0] r_cur_cmd, n_cur_cmd;
    logic [7:0] r_frame_id, n_frame_id;
    logic [7:0] r_last_id, n_last_id;
    logic [7:0] r_len, n_len;
    logic [7:0] r_count, n_count;
    logic [7:0] r_sum, n_sum;
    logic       ts;
    logic [8:0] cap;
    logic       emit;
    spdf_pkg::t_desc desc;

    assign ts  = (r_cur_cmd == r_state_cmd);
    assign cap = ts ? 9'(STATE_AREA_BYTES) : 9'(BUFFER_BYTES);

    always_comb begin
        n_phase    = r_phase;
        n_link     = r_link;
        n_cur_cmd  = r_cur_cmd;
        n_frame_id = r_frame_id;
        n_last_id  = r_last_id;
        n_len      = r_len;
        n_count    = r_count;
        n_sum      = r_sum;
        emit       = 1'b0;
        desc       = '0;
        desc.kind          = spdf_pkg::KIND_FINISHED;
        desc.to_state_area = ts;
        case (spdf_pkg::t_action'(i_action))
            spdf_pkg::ACT_START: begin
                emit            = 1'b1;
                desc.is_req     = 1'b1;
                desc.kind       = spdf_pkg::KIND_TX;
                desc.to_state_area = 1'b0;
                desc.byte_value = i_command;
                desc.req_id     = r_last_id;
                n_cur_cmd       = i_command;
                n_phase         = spdf_pkg::PH_HEADER;
            end
            spdf_pkg::ACT_TIMEOUT: begin
                if (r_phase != spdf_pkg::PH_IDLE) begin
                    emit        = 1'b1;
                    desc.status = r_link;
                    desc.frame_length = (r_phase == spdf_pkg::PH_DATA ||
                                         r_phase == spdf_pkg::PH_SUM) ? r_len : 8'd0;
                    n_phase     = spdf_pkg::PH_IDLE;
                end
            end
            spdf_pkg::ACT_BYTE: begin
                case (r_phase)
                    spdf_pkg::PH_HEADER: begin
                        if (i_rx_byte != spdf_pkg::HEADER_BYTE) begin
                            emit        = 1'b1;
                            desc.status = spdf_pkg::ST_HEADER;
                            n_link      = spdf_pkg::ST_HEADER;
                            n_phase     = spdf_pkg::PH_IDLE;
                        end else begin
                            n_link  = spdf_pkg::ST_TRUNC;
                            n_phase = spdf_pkg::PH_ID;
                        end
                    end
                    spdf_pkg::PH_ID: begin
                        n_frame_id = i_rx_byte;
                        n_sum      = i_rx_byte;
                        n_phase    = spdf_pkg::PH_LEN;
                    end
                    spdf_pkg::PH_LEN: begin
                        n_len   = i_rx_byte;
                        n_count = 8'd0;
                        n_phase = (i_rx_byte == 8'd0) ? spdf_pkg::PH_SUM : spdf_pkg::PH_DATA;
                    end
                    spdf_pkg::PH_DATA: begin
                        n_sum   = r_sum + i_rx_byte;
                        n_count = r_count + 8'd1;
                        if (n_count == r_len) begin
                            n_phase = spdf_pkg::PH_SUM;
                        end
                        // Bytes past the end of the target store still count.
                        if ({1'b0, r_count} < cap) begin
                            emit            = 1'b1;
                            desc.kind       = spdf_pkg::KIND_DATA;
                            desc.byte_value = i_rx_byte;
                            desc.data_index = r_count;
                        end
                    end
                    spdf_pkg::PH_SUM: begin
                        emit              = 1'b1;
                        desc.frame_length = r_len;
                        n_phase           = spdf_pkg::PH_IDLE;
                        if (i_rx_byte != r_sum) begin
                            desc.status = spdf_pkg::ST_CORRUPT;
                        end else begin
                            desc.status = spdf_pkg::ST_OK;
                            if (ts) begin
                                desc.accepted = 1'b1;
                            end else if (r_frame_id != r_last_id) begin
                                desc.accepted = 1'b1;
                                n_last_id     = r_frame_id;
                            end
                        end
                        n_link = desc.status;
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    assign o_desc_valid = i_accept && emit;
    assign o_desc       = desc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state_cmd <= 8'd0;
        end else if (i_cfg_we) begin
            r_state_cmd <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= spdf_pkg::PH_IDLE;
            r_link     <= spdf_pkg::ST_OFFLINE;
            r_cur_cmd  <= 8'd0;
            r_frame_id <= 8'd0;
            r_last_id  <= 8'd0;
            r_len      <= 8'd0;
            r_count    <= 8'd0;
            r_sum      <= 8'd0;
        end else if (i_accept) begin
            r_phase    <= n_phase;
            r_link     <= n_link;
            r_cur_cmd  <= n_cur_cmd;
            r_frame_id <= n_frame_id;
            r_last_id  <= n_last_id;
            r_len      <= n_len;
            r_count    <= n_count;
            r_sum      <= n_sum;
        end
    end

endmodule

/* hw/rtl/spdf_queue.sv */
module spdf_queue #(
    parameter int DEPTH = spdf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_wr,
    input  spdf_pkg::t_desc i_wr_desc,
    input  logic            i_rd,
    output logic            o_full,
    output logic            o_valid,
    output spdf_pkg::t_desc o_rd_desc
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    spdf_pkg::t_desc r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_wr, do_rd;

    assign o_full    = (r_count == CNT_W'(DEPTH));
    assign o_valid   = (r_count != '0);
    assign o_rd_desc = r_mem[r_rd_ptr];
    assign do_wr     = i_wr && !o_full;
    assign do_rd     = i_rd && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_wr_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_rd) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_wr && !do_rd) begin
                r_count <= r_count + 1'b1;
            end else if (do_rd && !do_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

/* hw/rtl/spdf_back.sv */
module spdf_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  spdf_pkg::t_desc i_q_desc,
    output logic            o_q_rd,
    input  logic            i_pop,
    output logic            o_empty,
    output logic [1:0]      o_kind,
    output logic [7:0]      o_byte_value,
    output logic [7:0]      o_data_index,
    output logic            o_to_state_area,
    output logic [2:0]      o_status,
    output logic            o_accepted,
    output logic [7:0]      o_frame_length,
    output logic            o_last
);

    logic       r_valid;
    logic [1:0] r_step;
    logic       load;
    logic       req_done;
    logic [7:0] tx_byte;

    assign load     = i_q_valid && (!r_valid || i_pop);
    assign req_done = (r_step == 2'd2);
    assign o_q_rd   = load && (!i_q_desc.is_req || req_done);
    assign o_empty  = !r_valid;

    always_comb begin
        case (r_step)
            2'd0:    tx_byte = spdf_pkg::REQUEST_BYTE;
            2'd1:    tx_byte = i_q_desc.byte_value;
            default: tx_byte = i_q_desc.req_id;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_step  <= 2'd0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
            end else if (i_pop) begin
                r_valid <= 1'b0;
            end
            if (load && i_q_desc.is_req) begin
                r_step <= req_done ? 2'd0 : r_step + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            o_kind          <= i_q_desc.kind;
            o_byte_value    <= i_q_desc.is_req ? tx_byte : i_q_desc.byte_value;
            o_data_index    <= i_q_desc.data_index;
            o_to_state_area <= i_q_desc.to_state_area;
            o_status        <= i_q_desc.status;
            o_accepted      <= i_q_desc.accepted;
            o_frame_length  <= i_q_desc.frame_length;
            o_last          <= !i_q_desc.is_req || req_done;
        end
    end

endmodule

/* hw/rtl/serial_packet_request_deframer_top.sv */
// Serial packet request deframer.
// Input channel: an item (action, command, rx_byte) transfers at a rising edge with push high
// and full low. A start item yields three transmit bytes (85, the command, the last accepted
// id); received bytes are parsed as a frame (header 170, id, length, data, sum) and yield
// payload results and a finished result; a timeout ends an open frame with the current status.
// Result channel: while empty is low the oldest result is on the o_ ports; it transfers at a
// rising edge with pop high and empty low. o_last marks the final result of an input item.
// Configuration: i_cfg_we writes i_cfg_data as the state-area command code; the user must write it only while
// idle, as the block does not enforce this. A result passes from the parser through the queue into the output
// register. The block takes one input item per cycle while full is low; the output register drains one result
// per cycle while pop is high, and a start item's three bytes leave it one after another.
// A four-entry queue between the parser and the output stage absorbs result bursts; when the
// receiver stalls the queue fills and full rises, holding off new items without losing any.
// Reset (synchronous, active low) empties the queue and output stage, returns the parser to
// idle with the link status offline, and clears the last id and the configuration register.
module serial_packet_request_deframer_top #(
    parameter int BUFFER_BYTES     = spdf_pkg::BUFFER_BYTES_DEF,
    parameter int STATE_AREA_BYTES = spdf_pkg::STATE_AREA_BYTES_DEF,
    parameter int QUEUE_DEPTH      = spdf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [1:0] i_action,
    input  logic [7:0] i_command,
    input  logic [7:0] i_rx_byte,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_data,
    output logic       empty,
    input  logic       pop,
    output logic [1:0] o_kind,
    output logic [7:0] o_byte_value,
    output logic [7:0] o_data_index,
    output logic       o_to_state_area,
    output logic [2:0] o_status,
    output logic       o_accepted,
    output logic [7:0] o_frame_length,
    output logic       o_last
);

`include "serial_packet_request_deframer_top_assert.svh"

    logic            in_xfer;
    logic            desc_valid;
    spdf_pkg::t_desc desc;
    logic            q_valid;
    logic            q_rd;
    spdf_pkg::t_desc q_desc;

    // The parser advances on every transfer; the queue has room whenever full is low.
    assign in_xfer = push && !full;

    spdf_front #(
        .BUFFER_BYTES     (BUFFER_BYTES),
        .STATE_AREA_BYTES (STATE_AREA_BYTES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (in_xfer),
        .i_action     (i_action),
        .i_command    (i_command),
        .i_rx_byte    (i_rx_byte),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .o_desc_valid (desc_valid),
        .o_desc       (desc)
    );

    spdf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (desc_valid),
        .i_wr_desc (desc),
        .i_rd      (q_rd),
        .o_full    (full),
        .o_valid   (q_valid),
        .o_rd_desc (q_desc)
    );

    spdf_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (q_valid),
        .i_q_desc        (q_desc),
        .o_q_rd          (q_rd),
        .i_pop           (pop),
        .o_empty         (empty),
        .o_kind          (o_kind),
        .o_byte_value    (o_byte_value),
        .o_data_index    (o_data_index),
        .o_to_state_area (o_to_state_area),
        .o_status        (o_status),
        .o_accepted      (o_accepted),
        .o_frame_length  (o_frame_length),
        .o_last          (o_last)
    );

    // Queued work must reach the output stage by the next cycle.
    `SPDF_ASSERT_NEXT(a_queue_drains, i_clk, i_rst_n, q_valid && empty, !empty, "queued result not loaded")

    // Only a frame with a good checksum can be accepted.
    `SPDF_ASSERT_SAME(a_accept_ok, i_clk, i_rst_n, !empty && o_accepted, o_status == spdf_pkg::ST_OK && o_kind == spdf_pkg::KIND_FINISHED, "accepted frame without ok status")

    // Only the first two bytes of a request are followed by more results of the same item.
    `SPDF_ASSERT_SAME(a_last_mark, i_clk, i_rst_n, !empty && !o_last, o_kind == spdf_pkg::KIND_TX, "non-last result is not a transmit byte")

endmodule

/* tb/tb_top.sv */
module tb_top;

    import spdf_pkg::*;

    // The run is ended by force if it has not finished by this many cycles.
    localparam int CYCLE_LIMIT    = 200000;
    localparam int ITEM_TARGET    = 410;
    localparam int MISMATCH_SHOWN = 10;
    // Cycles to let pass after the last expected result, so that items that
    // cause no result have left the pipeline before the next phase begins.
    localparam int SETTLE_CYCLES  = 4;

    // The action field is two bits wide; the fourth code does nothing.
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    // One result as it appears on the output ports.
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] byte_value;
        logic [7:0] data_index;
        logic       to_state_area;
        logic [2:0] status;
        logic       accepted;
        logic [7:0] frame_length;
        logic       last;
    } t_result;

    // How a generated reply frame is shaped.
    typedef enum int {
        FRAME_GOOD,
        FRAME_BAD_HEADER,
        FRAME_BAD_SUM,
        FRAME_CUT_TIMEOUT,
        FRAME_CUT_RESTART
    } t_frame_shape;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       push;
    logic       full;
    logic [1:0] i_action;
    logic [7:0] i_command;
    logic [7:0] i_rx_byte;
    logic       i_cfg_we;
    logic [7:0] i_cfg_data;
    logic       empty;
    logic       pop = 1'b0;
    logic [1:0] o_kind;
    logic [7:0] o_byte_value;
    logic [7:0] o_data_index;
    logic       o_to_state_area;
    logic [2:0] o_status;
    logic       o_accepted;
    logic [7:0] o_frame_length;
    logic       o_last;

    serial_packet_request_deframer_top uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_action        (i_action),
        .i_command       (i_command),
        .i_rx_byte       (i_rx_byte),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .empty           (empty),
        .pop             (pop),
        .o_kind          (o_kind),
        .o_byte_value    (o_byte_value),
        .o_data_index    (o_data_index),
        .o_to_state_area (o_to_state_area),
        .o_status        (o_status),
        .o_accepted      (o_accepted),
        .o_frame_length  (o_frame_length),
        .o_last          (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Mirror of the deframer state, advanced once per accepted input transfer.
    t_phase     prd_phase;
    logic [7:0] prd_state_code;
    logic [7:0] prd_cmd;
    logic [7:0] prd_frame_id;
    logic [7:0] prd_last_id;
    logic [7:0] prd_len;
    logic [7:0] prd_count;
    logic [7:0] prd_sum;
    t_status    prd_link;

    // Results the deframer still owes, oldest first.
    t_result    pending_results[$];

    int         fail_count  = 0;
    int         items_sent  = 0;
    int         cycle_count = 0;
    int         burst_left  = 0;
    int         rx_hold_left = 0;
    int         rx_mode = 0;
    int         rx_mode_left = 0;

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic void add_result(t_kind kind, logic [7:0] value, logic [7:0] index,
                                       logic to_state, t_status status, logic accepted,
                                       logic [7:0] length, logic last);
        t_result r;
        r.kind          = kind;
        r.byte_value    = value;
        r.data_index    = index;
        r.to_state_area = to_state;
        r.status        = status;
        r.accepted      = accepted;
        r.frame_length  = length;
        r.last          = last;
        pending_results.push_back(r);
    endfunction

    // Works out the results of one accepted item and updates the mirrored state.
    function automatic void predict_item(logic [1:0] act, logic [7:0] cmd, logic [7:0] rxb);
        logic       to_state;
        logic [7:0] idx;
        logic       acc;
        t_status    st;

        // A start always sends the request, even in the middle of a frame; the
        // open frame is dropped without a finished result.
        if (act == ACT_START) begin
            add_result(KIND_TX, REQUEST_BYTE, 8'd0, 1'b0, ST_OK, 1'b0, 8'd0, 1'b0);
            add_result(KIND_TX, cmd, 8'd0, 1'b0, ST_OK, 1'b0, 8'd0, 1'b0);
            add_result(KIND_TX, prd_last_id, 8'd0, 1'b0, ST_OK, 1'b0, 8'd0, 1'b1);
            prd_cmd   = cmd;
            prd_phase = PH_HEADER;
            return;
        end

        to_state = (prd_cmd == prd_state_code);

        if (act == ACT_TIMEOUT) begin
            // The length is reported only once the length byte has arrived.
            if (prd_phase != PH_IDLE) begin
                add_result(KIND_FINISHED, 8'd0, 8'd0, to_state, prd_link, 1'b0,
                           (prd_phase == PH_DATA || prd_phase == PH_SUM) ? prd_len : 8'd0,
                           1'b1);
                prd_phase = PH_IDLE;
            end
            return;
        end

        if (act != ACT_BYTE)
            return;

        case (prd_phase)
            PH_HEADER: begin
                if (rxb != HEADER_BYTE) begin
                    prd_link  = ST_HEADER;
                    prd_phase = PH_IDLE;
                    add_result(KIND_FINISHED, 8'd0, 8'd0, to_state, ST_HEADER, 1'b0, 8'd0,
                               1'b1);
                end else begin
                    prd_link  = ST_TRUNC;
                    prd_phase = PH_ID;
                end
            end
            PH_ID: begin
                prd_frame_id = rxb;
                prd_sum      = rxb;
                prd_phase    = PH_LEN;
            end
            PH_LEN: begin
                prd_len   = rxb;
                prd_count = 8'd0;
                prd_phase = (rxb == 8'd0) ? PH_SUM : PH_DATA;
            end
            PH_DATA: begin
                // Bytes past the end of the target store still count toward
                // the sum and the length but are not passed on.
                idx       = prd_count;
                prd_sum   = prd_sum + rxb;
                prd_count = prd_count + 8'd1;
                if (prd_count == prd_len)
                    prd_phase = PH_SUM;
                if (int'(idx) < (to_state ? STATE_AREA_BYTES_DEF : BUFFER_BYTES_DEF))
                    add_result(KIND_DATA, rxb, idx, to_state, ST_OK, 1'b0, 8'd0, 1'b1);
            end
            PH_SUM: begin
                acc = 1'b0;
                if (rxb != prd_sum) begin
                    st = ST_CORRUPT;
                end else begin
                    st = ST_OK;
                    // State-area frames are always taken; others only when the id
                    // is new, and only those update the remembered id.
                    if (to_state) begin
                        acc = 1'b1;
                    end else if (prd_frame_id != prd_last_id) begin
                        prd_last_id = prd_frame_id;
                        acc = 1'b1;
                    end
                end
                prd_link  = st;
                prd_phase = PH_IDLE;
                add_result(KIND_FINISHED, 8'd0, 8'd0, to_state, st, acc, prd_len, 1'b1);
            end
            default: begin
            end
        endcase
    endfunction

    // Offers one item and returns at the edge where it transfers. The sender
    // works in bursts; between bursts push drops for a random number of cycles.
    // Push stays high on return, so any caller that waits for something else
    // must lower it first.
    task automatic send_item(input logic [1:0] act, input logic [7:0] cmd,
                             input logic [7:0] rxb);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                @(negedge i_clk);
                push <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        @(negedge i_clk);
        push      <= 1'b1;
        i_action  <= act;
        i_command <= cmd;
        i_rx_byte <= rxb;
        @(posedge i_clk);
        while (full)
            @(posedge i_clk);
        predict_item(act, cmd, rxb);
        items_sent++;
        burst_left--;
    endtask

    // Stops offering and waits until every owed result has been popped.
    task automatic wait_drained();
        @(negedge i_clk);
        push <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // The code register is only written with the parser idle, so an open frame
    // is closed by a timeout first.
    task automatic set_config(input logic [7:0] code);
        wait_drained();
        if (prd_phase != PH_IDLE) begin
            send_item(ACT_TIMEOUT, rand_byte(), rand_byte());
            wait_drained();
        end
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= code;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        prd_state_code = code;
    endtask

    // Sends a request and then the reply frame, shaped as asked. Cut frames
    // stop after a random number of bytes; a restart cut is closed by the next
    // start, a timeout cut by a timeout item.
    task automatic send_frame(input logic [7:0] cmd, input logic [7:0] id,
                              input logic [7:0] len, input t_frame_shape shape);
        logic [7:0] frame_bytes[$];
        logic [7:0] sum;
        logic [7:0] b;
        int         cut;

        send_item(ACT_START, cmd, rand_byte());
        if (shape == FRAME_BAD_HEADER) begin
            do
                b = rand_byte();
            while (b == HEADER_BYTE);
            send_item(ACT_BYTE, rand_byte(), b);
            return;
        end

        sum = id;
        frame_bytes = {HEADER_BYTE, id, len};
        for (int i = 0; i < len; i++) begin
            b = rand_byte();
            sum = sum + b;
            frame_bytes.push_back(b);
        end
        if (shape == FRAME_BAD_SUM)
            sum = sum ^ 8'($urandom_range(1, 255));
        frame_bytes.push_back(sum);

        cut = frame_bytes.size();
        if (shape == FRAME_CUT_TIMEOUT || shape == FRAME_CUT_RESTART)
            cut = $urandom_range(0, (cut - 1 < 12) ? cut - 1 : 12);
        for (int i = 0; i < cut; i++)
            send_item(ACT_BYTE, rand_byte(), frame_bytes[i]);
        if (shape == FRAME_CUT_TIMEOUT)
            send_item(ACT_TIMEOUT, rand_byte(), rand_byte());
    endtask

    // Items that must be ignored while idle, then a timeout straight after a
    // request, which reports the offline status that reset leaves behind.
    task automatic test_idle_noise();
        send_item(ACT_TIMEOUT, 8'h00, 8'h00);
        send_item(ACT_BYTE, 8'hFF, 8'hFF);
        send_item(ACT_UNUSED, 8'hFF, 8'h00);
        send_item(ACT_START, 8'h00, 8'hFF);
        send_item(ACT_TIMEOUT, 8'hFF, 8'hFF);
        wait_drained();
    endtask

    task automatic test_header_error();
        send_frame(8'hFF, 8'h00, 8'h00, FRAME_BAD_HEADER);
        wait_drained();
    endtask

    // A timeout in the data bytes reports truncated along with the length.
    task automatic test_truncation();
        send_item(ACT_START, 8'h7E, 8'h00);
        send_item(ACT_BYTE, 8'h00, HEADER_BYTE);
        send_item(ACT_BYTE, 8'hFF, 8'h00);
        send_item(ACT_BYTE, 8'h00, 8'd3);
        send_item(ACT_BYTE, 8'h00, 8'hFF);
        send_item(ACT_TIMEOUT, 8'h00, 8'h00);
        wait_drained();
    endtask

    // A new id is taken, the same id again is refused, a bad sum is corrupt.
    // The zero-length frames go straight from the length to the checksum.
    task automatic test_checksum_and_ids();
        send_frame(8'h81, 8'h42, 8'd1, FRAME_GOOD);
        send_frame(8'h18, 8'h42, 8'd0, FRAME_GOOD);
        send_frame(8'h81, 8'h43, 8'd0, FRAME_BAD_SUM);
        wait_drained();
    endtask

    // The receiver holds off while the sender keeps offering, so the result
    // queue fills and full holds the input back. Afterwards the sender waits
    // for every owed result before going on.
    task automatic test_back_pressure();
        wait_drained();
        rx_hold_left = 60;
        burst_left   = 40;
        for (int i = 0; i < 4; i++)
            send_frame(rand_byte(), rand_byte(), 8'd3, FRAME_GOOD);
        wait_drained();
    endtask

    // Mostly well-formed frames with random content, mixed with broken frames
    // and stray items. The state-area code is rewritten every dozen frames, and the
    // command and id often repeat the code and the last id on purpose.
    task automatic test_random_traffic();
        int           frames;
        int           r;
        logic [7:0]   cmd;
        logic [7:0]   id;
        logic [7:0]   len;
        t_frame_shape shape;

        frames = 0;
        while (items_sent < ITEM_TARGET) begin
            if (frames % 12 == 0) begin
                r = $urandom_range(0, 3);
                if (frames == 0 || r == 1)
                    set_config(8'hFF);
                else if (r == 0)
                    set_config(8'h00);
                else
                    set_config(rand_byte());
            end
            frames++;

            cmd = ($urandom_range(0, 2) == 0) ? prd_state_code : rand_byte();
            id  = ($urandom_range(0, 2) == 0) ? prd_last_id : rand_byte();
            len = ($urandom_range(0, 6) == 0) ? 8'($urandom_range(9, 40))
                                              : 8'($urandom_range(0, 8));
            r = $urandom_range(0, 99);
            if (r < 60) begin
                shape = FRAME_GOOD;
            end else if (r < 70) begin
                shape = FRAME_BAD_SUM;
            end else if (r < 78) begin
                shape = FRAME_BAD_HEADER;
            end else if (r < 88) begin
                shape = FRAME_CUT_TIMEOUT;
                len   = rand_byte();
            end else if (r < 94) begin
                shape = FRAME_CUT_RESTART;
                len   = rand_byte();
            end else begin
                repeat ($urandom_range(1, 3))
                    send_item(2'($urandom_range(0, 3)), rand_byte(), rand_byte());
                continue;
            end
            send_frame(cmd, id, len, shape);
        end
        wait_drained();
    endtask

    // The receiver alternates between stretches of steady popping and
    // stretches with light or heavy stalls. A hold-off request overrides it.
    always @(negedge i_clk) begin
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            pop <= 1'b0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode      = $urandom_range(0, 3);
                rx_mode_left = $urandom_range(16, 96);
            end
            rx_mode_left--;
            case (rx_mode)
                0:       pop <= 1'b1;
                1:       pop <= 1'($urandom_range(0, 1));
                2:       pop <= ($urandom_range(0, 3) == 0);
                default: pop <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    task automatic report_bad(input string what, input t_result want, input t_result got);
        fail_count++;
        if (fail_count <= MISMATCH_SHOWN)
            $display("%s: expected kind=%0d byte=%0d idx=%0d state=%0d status=%0d acc=%0d len=%0d last=%0d got kind=%0d byte=%0d idx=%0d state=%0d status=%0d acc=%0d len=%0d last=%0d",
                     what, want.kind, want.byte_value, want.data_index, want.to_state_area,
                     want.status, want.accepted, want.frame_length, want.last,
                     got.kind, got.byte_value, got.data_index, got.to_state_area,
                     got.status, got.accepted, got.frame_length, got.last);
    endtask

    // Every result transfer is checked against the oldest owed result.
    always @(posedge i_clk) begin : result_check
        t_result got;
        t_result want;
        if (i_rst_n === 1'b1 && pop && !empty) begin
            got = {o_kind, o_byte_value, o_data_index, o_to_state_area, o_status,
                   o_accepted, o_frame_length, o_last};
            if (pending_results.size() == 0) begin
                want = '0;
                report_bad("unexpected result", want, got);
            end else begin
                want = pending_results.pop_front();
                if (got !== want)
                    report_bad("result mismatch", want, got);
            end
        end
    end

    // Guards against a hang anywhere in the run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        i_rst_n    = 1'b0;
        push       = 1'b0;
        i_action   = ACT_START;
        i_command  = 8'd0;
        i_rx_byte  = 8'd0;
        i_cfg_we   = 1'b0;
        i_cfg_data = 8'd0;

        prd_phase      = PH_IDLE;
        prd_state_code = 8'd0;
        prd_cmd        = 8'd0;
        prd_frame_id   = 8'd0;
        prd_last_id    = 8'd0;
        prd_len        = 8'd0;
        prd_count      = 8'd0;
        prd_sum        = 8'd0;
        prd_link       = ST_OFFLINE;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_idle_noise();
        test_header_error();
        test_truncation();
        test_checksum_and_ids();
        test_back_pressure();
        test_random_traffic();

        // Anything that shows up now was never owed and is flagged by the checker.
        repeat (10) @(posedge i_clk);
        if (pending_results.size() != 0)
            fail_count++;

        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
